>>> rtl/aabbt_pkg.sv
package aabbt_pkg;

  // Number formats: signed Q16.16 coordinates and signed Q4.12 weights.
  localparam int unsigned CoordWidth  = 32;
  localparam int unsigned WeightWidth = 16;
  localparam int unsigned WeightFrac  = 12;
  localparam int unsigned Axes        = 3;

  // Configuration port geometry.
  localparam int unsigned CfgIndexWidth = 3;
  localparam int unsigned CfgDataWidth  =
    (Axes * WeightWidth > CoordWidth) ? Axes * WeightWidth : CoordWidth;

  // Register indexes on the configuration port.
  localparam logic [CfgIndexWidth-1:0] CfgXWeights = 3'd0;
  localparam logic [CfgIndexWidth-1:0] CfgYWeights = 3'd1;
  localparam logic [CfgIndexWidth-1:0] CfgZWeights = 3'd2;
  localparam logic [CfgIndexWidth-1:0] CfgShiftX   = 3'd3;
  localparam logic [CfgIndexWidth-1:0] CfgShiftY   = 3'd4;
  localparam logic [CfgIndexWidth-1:0] CfgShiftZ   = 3'd5;

  // Derived datapath widths.
  localparam int unsigned ProdWidth = CoordWidth + WeightWidth;
  localparam int unsigned SumWidth  = ProdWidth + 2;
  localparam int unsigned ShWidth   = SumWidth - WeightFrac;
  localparam int unsigned AccWidth  = ((ShWidth > CoordWidth) ? ShWidth : CoordWidth) + 1;

  // A weight of exactly one.
  localparam logic [WeightWidth-1:0] WeightOne =
    {{(WeightWidth-1){1'b0}}, 1'b1} << WeightFrac;

  typedef logic signed [CoordWidth-1:0]     coord_t;
  typedef logic signed [ProdWidth-1:0]      prod_t;
  typedef logic [Axes*WeightWidth-1:0]      weights_t;

endpackage

>>> rtl/aabb_transform.sv
// Pipeline: a word accepted at the input passes the input, product and result
// registers in turn. Throughput: one box per cycle unless the output stalls;
// all 18 coordinate-by-weight products work in parallel.
// Reset (asynchronous, active low) empties the pipeline and loads the
// identity matrix with zero translation.
module aabb_transform (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [aabbt_pkg::CfgIndexWidth-1:0]  cfg_index_i,
  input  logic [aabbt_pkg::CfgDataWidth-1:0]   cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic signed [aabbt_pkg::CoordWidth-1:0] low_x_i,
  input  logic signed [aabbt_pkg::CoordWidth-1:0] low_y_i,
  input  logic signed [aabbt_pkg::CoordWidth-1:0] low_z_i,
  input  logic signed [aabbt_pkg::CoordWidth-1:0] high_x_i,
  input  logic signed [aabbt_pkg::CoordWidth-1:0] high_y_i,
  input  logic signed [aabbt_pkg::CoordWidth-1:0] high_z_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [aabbt_pkg::CoordWidth-1:0] out_low_x_o,
  output logic signed [aabbt_pkg::CoordWidth-1:0] out_low_y_o,
  output logic signed [aabbt_pkg::CoordWidth-1:0] out_low_z_o,
  output logic signed [aabbt_pkg::CoordWidth-1:0] out_high_x_o,
  output logic signed [aabbt_pkg::CoordWidth-1:0] out_high_y_o,
  output logic signed [aabbt_pkg::CoordWidth-1:0] out_high_z_o
);
  import aabbt_pkg::*;

  // Configuration registers.
  weights_t wgt_q [Axes];
  coord_t   shf_q [Axes];

  // Pipeline registers.
  logic   in_v_q, prod_v_q, out_v_q;
  coord_t lo_q [Axes];
  coord_t hi_q [Axes];
  prod_t  plo_q [Axes][Axes];
  prod_t  phi_q [Axes][Axes];
  coord_t omin_q [Axes];
  coord_t omax_q [Axes];

  prod_t  plo_d [Axes][Axes];
  prod_t  phi_d [Axes][Axes];
  coord_t omin_d [Axes];
  coord_t omax_d [Axes];

  logic en_in, en_prod, en_out;

  // Each stage moves when it is empty or the stage after it moves.
  assign en_out  = !out_v_q || !out_stall_i;
  assign en_prod = !prod_v_q || en_out;
  assign en_in   = !in_v_q || en_prod;
  assign in_stall_o = !en_in;

  // Configuration writes; indexes beyond the list are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int a = 0; a < Axes; a++) begin
        wgt_q[a] <= weights_t'(WeightOne) << (a * WeightWidth);
        shf_q[a] <= '0;
      end
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CfgXWeights: wgt_q[0] <= cfg_data_i[Axes*WeightWidth-1:0];
        CfgYWeights: wgt_q[1] <= cfg_data_i[Axes*WeightWidth-1:0];
        CfgZWeights: wgt_q[2] <= cfg_data_i[Axes*WeightWidth-1:0];
        CfgShiftX:   shf_q[0] <= cfg_data_i[CoordWidth-1:0];
        CfgShiftY:   shf_q[1] <= cfg_data_i[CoordWidth-1:0];
        CfgShiftZ:   shf_q[2] <= cfg_data_i[CoordWidth-1:0];
        default: ;
      endcase
    end
  end

  // Valid bits of the three stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q   <= 1'b0;
      prod_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      if (en_in)   in_v_q   <= in_valid_i;
      if (en_prod) prod_v_q <= in_v_q;
      if (en_out)  out_v_q  <= prod_v_q;
    end
  end

  // Input register holds the box corners.
  always_ff @(posedge clk_i) begin
    if (en_in && in_valid_i) begin
      lo_q[0] <= low_x_i;
      lo_q[1] <= low_y_i;
      lo_q[2] <= low_z_i;
      hi_q[0] <= high_x_i;
      hi_q[1] <= high_y_i;
      hi_q[2] <= high_z_i;
    end
  end

  // Every coordinate bound times every weight; index [axis][coordinate].
  always_comb begin
    for (int a = 0; a < Axes; a++) begin
      for (int k = 0; k < Axes; k++) begin
        plo_d[a][k] = lo_q[k] * $signed(wgt_q[a][k*WeightWidth +: WeightWidth]);
        phi_d[a][k] = hi_q[k] * $signed(wgt_q[a][k*WeightWidth +: WeightWidth]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_prod && in_v_q) begin
      plo_q <= plo_d;
      phi_q <= phi_d;
    end
  end

  // The transform is a sum of independent per-coordinate terms, so the corner
  // extremes come from summing each term's smaller or larger product. Floor
  // shift, translation and clamp are monotonic and keep that order.
  always_comb begin
    prod_t                       tmin, tmax;
    logic signed [SumWidth-1:0]  smin, smax;
    logic signed [AccWidth-1:0]  amin, amax;
    for (int a = 0; a < Axes; a++) begin
      smin = '0;
      smax = '0;
      for (int k = 0; k < Axes; k++) begin
        if (plo_q[a][k] < phi_q[a][k]) begin
          tmin = plo_q[a][k];
          tmax = phi_q[a][k];
        end else begin
          tmin = phi_q[a][k];
          tmax = plo_q[a][k];
        end
        smin = smin + {{(SumWidth-ProdWidth){tmin[ProdWidth-1]}}, tmin};
        smax = smax + {{(SumWidth-ProdWidth){tmax[ProdWidth-1]}}, tmax};
      end
      amin = AccWidth'(smin >>> WeightFrac) + AccWidth'(shf_q[a]);
      amax = AccWidth'(smax >>> WeightFrac) + AccWidth'(shf_q[a]);
      // Clamp when the bits above the coordinate sign differ from it.
      if (amin[AccWidth-1:CoordWidth-1] != {(AccWidth-CoordWidth+1){amin[AccWidth-1]}}) begin
        omin_d[a] = {amin[AccWidth-1], {(CoordWidth-1){!amin[AccWidth-1]}}};
      end else begin
        omin_d[a] = amin[CoordWidth-1:0];
      end
      if (amax[AccWidth-1:CoordWidth-1] != {(AccWidth-CoordWidth+1){amax[AccWidth-1]}}) begin
        omax_d[a] = {amax[AccWidth-1], {(CoordWidth-1){!amax[AccWidth-1]}}};
      end else begin
        omax_d[a] = amax[CoordWidth-1:0];
      end
    end
  end

  // Result register.
  always_ff @(posedge clk_i) begin
    if (en_out && prod_v_q) begin
      omin_q <= omin_d;
      omax_q <= omax_d;
    end
  end

  assign out_valid_o  = out_v_q;
  assign out_low_x_o  = omin_q[0];
  assign out_low_y_o  = omin_q[1];
  assign out_low_z_o  = omin_q[2];
  assign out_high_x_o = omax_q[0];
  assign out_high_y_o = omax_q[1];
  assign out_high_z_o = omax_q[2];

endmodule

>>> rtl/aabbt_checker.sv
module aabbt_checker (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    in_valid_i,
  input  logic                                    in_stall_o,
  input  logic                                    out_valid_o,
  input  logic                                    out_stall_i,
  input  logic signed [aabbt_pkg::CoordWidth-1:0] out_low_x_o,
  input  logic signed [aabbt_pkg::CoordWidth-1:0] out_low_y_o,
  input  logic signed [aabbt_pkg::CoordWidth-1:0] out_low_z_o,
  input  logic signed [aabbt_pkg::CoordWidth-1:0] out_high_x_o,
  input  logic signed [aabbt_pkg::CoordWidth-1:0] out_high_y_o,
  input  logic signed [aabbt_pkg::CoordWidth-1:0] out_high_z_o
);
  import aabbt_pkg::*;

  // A stalled input word stays offered.
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i)
    else $error("input word withdrawn while stalled");

  // A stalled result word stays valid.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result word dropped while stalled");

  // A stalled result word keeps its payload.
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_low_x_o) && $stable(out_high_x_o)
      && $stable(out_low_y_o) && $stable(out_high_y_o)
      && $stable(out_low_z_o) && $stable(out_high_z_o))
    else $error("result word changed while stalled");

  // The input side only backs up when the full pipeline waits on the output.
  a_in_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled with room in the pipeline");

  // The enclosing box is never inverted.
  a_ordered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_low_x_o <= out_high_x_o && out_low_y_o <= out_high_y_o
      && out_low_z_o <= out_high_z_o)
    else $error("result box has low above high");

endmodule

bind aabb_transform aabbt_checker u_aabbt_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .out_low_x_o  (out_low_x_o),
  .out_low_y_o  (out_low_y_o),
  .out_low_z_o  (out_low_z_o),
  .out_high_x_o (out_high_x_o),
  .out_high_y_o (out_high_y_o),
  .out_high_z_o (out_high_z_o)
);
